// ===== design/knsl_pkg.sv =====
package knsl_pkg;

    // Field widths
    localparam int C_DIST_W = 32;
    localparam int C_IDX_W  = 16;
    localparam int C_LEN_W  = 5;
    localparam int C_RANK_W = 4;

    // Most words one run may emit
    localparam int C_EMIT_CAP = 16;

    // Reset values
    localparam logic [C_LEN_W-1:0]  C_LEN_RST  = 5'd16;
    localparam logic [C_DIST_W-1:0] C_DIST_RST = '1;

    // Config register indexes
    typedef enum logic {
        REG_LIST_LENGTH = 1'b0,
        REG_INIT_DIST   = 1'b1
    } t_reg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Command broadcast along the cell row
    typedef struct packed {
        logic               insert;  // take a candidate this cycle
        logic               clear;   // reload all slots before the insert
        logic               rotate;  // shift active slots toward slot 0, wrap
        logic [C_LEN_W-1:0] len;     // active slot count, 1..16
    } t_row_cmd;

endpackage

// ===== design/knsl_cell.sv =====
module knsl_cell
    import knsl_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_row_cmd            i_cmd,
    input  logic [C_DIST_W-1:0] i_init_dist,
    input  logic [C_DIST_W-1:0] i_dist,
    input  logic [C_IDX_W-1:0]  i_idx,
    input  logic                i_found,
    input  logic [C_DIST_W-1:0] i_prev_dist,
    input  logic [C_IDX_W-1:0]  i_prev_idx,
    input  logic [C_DIST_W-1:0] i_next_dist,
    input  logic [C_IDX_W-1:0]  i_next_idx,
    input  logic [C_DIST_W-1:0] i_head_dist,
    input  logic [C_IDX_W-1:0]  i_head_idx,
    output logic                o_found,
    output logic [C_DIST_W-1:0] o_eff_dist,
    output logic [C_IDX_W-1:0]  o_eff_idx,
    output logic [C_DIST_W-1:0] o_dist,
    output logic [C_IDX_W-1:0]  o_idx
);

    logic [C_DIST_W-1:0] r_dist, n_dist;
    logic [C_IDX_W-1:0]  r_idx, n_idx;
    logic                w_active, w_tail, w_gt;

    // Slot position against the active length
    assign w_active = 32'(IDX) < 32'(i_cmd.len);
    assign w_tail   = 32'(IDX) + 32'd1 == 32'(i_cmd.len);

    // Slot content as seen after an optional clear
    assign o_eff_dist = i_cmd.clear ? i_init_dist : r_dist;
    assign o_eff_idx  = i_cmd.clear ? '0 : r_idx;

    // Insert point: first active slot holding a larger distance
    assign w_gt    = w_active && (o_eff_dist > i_dist);
    assign o_found = i_found | w_gt;

    always_comb begin
        n_dist = r_dist;
        n_idx  = r_idx;
        priority if (i_cmd.insert) begin
            n_dist = o_eff_dist;
            n_idx  = o_eff_idx;
            if (w_active && i_found) begin
                n_dist = i_prev_dist;
                n_idx  = i_prev_idx;
            end else if (w_gt) begin
                n_dist = i_dist;
                n_idx  = i_idx;
            end
        end else if (i_cmd.rotate && w_active) begin
            n_dist = w_tail ? i_head_dist : i_next_dist;
            n_idx  = w_tail ? i_head_idx : i_next_idx;
        end else begin
            n_dist = r_dist;
            n_idx  = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= C_DIST_RST;
            r_idx  <= '0;
        end else begin
            r_dist <= n_dist;
            r_idx  <= n_idx;
        end
    end

    assign o_dist = r_dist;
    assign o_idx  = r_idx;

endmodule

// ===== design/knsl_ctrl.sv =====
module knsl_ctrl
    import knsl_pkg::*;
#(
    parameter int LIST_SIZE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_first,
    input  logic                i_last,
    output logic                o_in_stall,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [C_DIST_W-1:0] i_cfg_data,
    output logic                o_cfg_ready,
    input  logic [C_DIST_W-1:0] i_head_dist,
    input  logic [C_IDX_W-1:0]  i_head_idx,
    output t_row_cmd            o_cmd,
    output logic [C_DIST_W-1:0] o_init_dist,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [C_RANK_W-1:0] o_rank,
    output logic [C_DIST_W-1:0] o_dist,
    output logic [C_IDX_W-1:0]  o_idx,
    output logic                o_last
);

    localparam int EMIT_MAX = (LIST_SIZE < C_EMIT_CAP) ? LIST_SIZE : C_EMIT_CAP;

    t_state                r_state, n_state;
    logic [C_LEN_W-1:0]    r_len;
    logic [C_DIST_W-1:0]   r_init;
    logic [C_RANK_W-1:0]   r_cnt;
    logic                  r_out_valid;
    logic [C_RANK_W-1:0]   r_rank;
    logic [C_DIST_W-1:0]   r_dist;
    logic [C_IDX_W-1:0]    r_idx;
    logic                  r_last;
    logic [C_LEN_W-1:0]    w_n;
    logic                  w_accept, w_load, w_last_word, w_cfg_wr;

    // Active length: saturate into 1..EMIT_MAX
    always_comb begin
        priority if (r_len == '0) begin
            w_n = C_LEN_W'(1);
        end else if (r_len > C_LEN_W'(EMIT_MAX)) begin
            w_n = C_LEN_W'(EMIT_MAX);
        end else begin
            w_n = r_len;
        end
    end

    // Config registers, written only between runs
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= C_LEN_RST;
            r_init <= C_DIST_RST;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LIST_LENGTH: r_len  <= i_cfg_data[C_LEN_W-1:0];
                REG_INIT_DIST:   r_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_init_dist = r_init;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_load      = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_last_word = ({1'b0, r_cnt} == w_n - C_LEN_W'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept && i_last) n_state = ST_EMIT;
            ST_EMIT: if (w_load && w_last_word) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd.insert = 1'b0;
        o_cmd.clear  = 1'b0;
        o_cmd.rotate = 1'b0;
        o_cmd.len    = w_n;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.insert = i_in_valid;
                o_cmd.clear  = i_in_valid && i_first;
            end
            ST_EMIT: begin
                o_cmd.rotate = w_load;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (w_load) begin
                r_cnt <= r_cnt + C_RANK_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word register, fed from slot 0 as the row rotates
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rank <= r_cnt;
            r_dist <= i_head_dist;
            r_idx  <= i_head_idx;
            r_last <= w_last_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rank      = r_rank;
    assign o_dist      = r_dist;
    assign o_idx       = r_idx;
    assign o_last      = r_last;

    // No candidate enters the row while it is rotating out
    a_no_insert_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.insert && o_cmd.rotate))
        else $error("insert during emission");

    // Count stays inside the active list during a run
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ({1'b0, r_cnt} < w_n))
        else $error("emit count past list length");

    // A run starts only on an accepted last candidate
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && $past(r_state) == ST_IDLE) |-> $past(w_accept && i_last))
        else $error("emission without last candidate");

    // Loading the final rank ends the run
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last_word) |=> (r_state == ST_IDLE && r_out_valid && r_last))
        else $error("run did not end on final rank");

endmodule

// ===== design/k_nearest_sorted_list.sv =====
// Channel   Handshake                       Word
// input     i_in_valid / o_in_stall         distance, candidate index, first/last flags
// output    o_out_valid / i_out_stall       rank, kept distance, neighbour index, last flag
// config    i_cfg_valid / o_cfg_ready       register index, write data
//
// A candidate is absorbed by the cell row as it is accepted; a candidate without
// the last flag frees the input for the next cycle.
// A last candidate is followed by n output words (n = active length, 1..16):
// the row rotates one slot per cycle into the output register and is back in
// order after the run; input and config wait for that.
// An output stall freezes the rotation. Synchronous reset fills every slot
// with all ones and index zero; no clearing pass.
module k_nearest_sorted_list
    import knsl_pkg::*;
#(
    parameter int LIST_SIZE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [C_DIST_W-1:0] i_distance,
    input  logic [C_IDX_W-1:0]  i_candidate_index,
    input  logic                i_first_candidate,
    input  logic                i_last_candidate,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [C_RANK_W-1:0] o_rank,
    output logic [C_DIST_W-1:0] o_kept_distance,
    output logic [C_IDX_W-1:0]  o_neighbour_index,
    output logic                o_last_of_run,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [C_DIST_W-1:0] i_cfg_data
);

    t_row_cmd            w_cmd;
    logic [C_DIST_W-1:0] w_init_dist;
    logic [C_DIST_W-1:0] w_dist     [LIST_SIZE];
    logic [C_IDX_W-1:0]  w_idx      [LIST_SIZE];
    logic [C_DIST_W-1:0] w_eff_dist [LIST_SIZE];
    logic [C_IDX_W-1:0]  w_eff_idx  [LIST_SIZE];
    logic                w_found    [LIST_SIZE];

    knsl_ctrl #(
        .LIST_SIZE (LIST_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_first     (i_first_candidate),
        .i_last      (i_last_candidate),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_head_dist (w_dist[0]),
        .i_head_idx  (w_idx[0]),
        .o_cmd       (w_cmd),
        .o_init_dist (w_init_dist),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rank      (o_rank),
        .o_dist      (o_kept_distance),
        .o_idx       (o_neighbour_index),
        .o_last      (o_last_of_run)
    );

    // Cell row: insert ripples toward the tail, rotation toward slot 0
    for (genvar g = 0; g < LIST_SIZE; g++) begin : g_cell
        logic                w_found_in;
        logic [C_DIST_W-1:0] w_prev_dist, w_next_dist;
        logic [C_IDX_W-1:0]  w_prev_idx, w_next_idx;

        if (g == 0) begin : g_head
            assign w_found_in  = 1'b0;
            assign w_prev_dist = i_distance;
            assign w_prev_idx  = i_candidate_index;
        end else begin : g_body
            assign w_found_in  = w_found[g-1];
            assign w_prev_dist = w_eff_dist[g-1];
            assign w_prev_idx  = w_eff_idx[g-1];
        end

        if (g == LIST_SIZE - 1) begin : g_end
            assign w_next_dist = w_dist[0];
            assign w_next_idx  = w_idx[0];
        end else begin : g_mid
            assign w_next_dist = w_dist[g+1];
            assign w_next_idx  = w_idx[g+1];
        end

        knsl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_init_dist (w_init_dist),
            .i_dist      (i_distance),
            .i_idx       (i_candidate_index),
            .i_found     (w_found_in),
            .i_prev_dist (w_prev_dist),
            .i_prev_idx  (w_prev_idx),
            .i_next_dist (w_next_dist),
            .i_next_idx  (w_next_idx),
            .i_head_dist (w_dist[0]),
            .i_head_idx  (w_idx[0]),
            .o_found     (w_found[g]),
            .o_eff_dist  (w_eff_dist[g]),
            .o_eff_idx   (w_eff_idx[g]),
            .o_dist      (w_dist[g]),
            .o_idx       (w_idx[g])
        );
    end

endmodule
